[src/mpma_pkg.sv]
// shared types, constants and helpers of the mux port mapping allocator
`default_nettype none

package mpma_pkg;

	localparam int NUM_PORTS   = 8;
	localparam int MAX_RESULTS = 8;
	localparam int FIELD_W     = 3;
	localparam int IDX_W       = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int CNT_W       = $clog2(MAX_RESULTS);
	localparam int WIDE_W      = FIELD_W + IDX_W;

	typedef logic [FIELD_W-1:0]   field_t;
	typedef logic [IDX_W-1:0]     addr_t;
	typedef logic [NUM_PORTS-1:0] mask_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	localparam field_t OP_CONNECT    = 3'd0;
	localparam field_t OP_DISCONNECT = 3'd1;
	localparam field_t OP_LOOKUP     = 3'd2;
	localparam field_t OP_LIST_FREE  = 3'd3;
	localparam field_t OP_FILL       = 3'd4;

	localparam addr_t LAST_ADDR = addr_t'(NUM_PORTS - 1);
	localparam cnt_t  LAST_CNT  = cnt_t'(MAX_RESULTS - 1);

	typedef struct packed {
		logic   valid;
		field_t target;
	} entry_t;

	typedef struct packed {
		logic   en;
		addr_t  addr;
		entry_t data;
	} tbl_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_EMIT,
		ST_FILL,
		ST_WAIT
	} state_t;

	// field value as a table address, extended or cut to the table's width
	function automatic addr_t to_addr(field_t f);
		logic [WIDE_W-1:0] w;
		w = {{IDX_W{1'b0}}, f};
		return w[IDX_W-1:0];
	endfunction

	// table address as a 3-bit field value
	function automatic field_t to_field(addr_t a);
		logic [WIDE_W-1:0] w;
		w = {{FIELD_W{1'b0}}, a};
		return w[FIELD_W-1:0];
	endfunction

	function automatic logic in_range(field_t f);
		return ({{IDX_W{1'b0}}, f} < WIDE_W'(NUM_PORTS));
	endfunction

	// position of the lowest set bit, zero for an empty mask
	function automatic addr_t lowest(mask_t m);
		addr_t r;
		r = '0;
		for (int i = NUM_PORTS - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = addr_t'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[src/mpma_if.sv]
// valid/ready channel interfaces for request and result beats
`default_nettype none

interface mpma_in_if;
	import mpma_pkg::*;

	logic   valid;
	logic   ready;
	field_t op;
	field_t in_sel;
	field_t out_sel;

	modport source (output valid, output op, output in_sel, output out_sel,
		input ready);
	modport sink (input valid, input op, input in_sel, input out_sel,
		output ready);
endinterface

interface mpma_out_if;
	import mpma_pkg::*;

	logic   valid;
	logic   ready;
	logic   index_valid;
	field_t out_index;
	logic   last;

	modport source (output valid, output index_valid, output out_index, output last,
		input ready);
	modport sink (input valid, input index_valid, input out_index, input last,
		output ready);
endinterface

`default_nettype wire

[src/mpma_table.sv]
// mapping table: one entry per mux input, one write and one read port
`default_nettype none

module mpma_table (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mpma_pkg::tbl_wr_t wr,
	input  wire mpma_pkg::addr_t  rd_addr,
	output mpma_pkg::entry_t      rd_data
);
	import mpma_pkg::*;

	logic   valid_q  [NUM_PORTS];
	field_t target_q [NUM_PORTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PORTS; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (wr.en) begin
			valid_q[wr.addr] <= wr.data.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			target_q[wr.addr] <= wr.data.target;
		end
	end

	always_comb begin
		rd_data.valid  = valid_q[rd_addr];
		rd_data.target = target_q[rd_addr];
	end

endmodule

`default_nettype wire

[src/mpma_ctrl.sv]
// sequencer: walks the table one entry a cycle, builds the free mask, emits results
`default_nettype none

module mpma_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	mpma_in_if.sink                in_ch,
	mpma_out_if.source             out_ch,
	output mpma_pkg::tbl_wr_t      wr,
	output mpma_pkg::addr_t        rd_addr,
	input  wire mpma_pkg::entry_t  rd_data
);
	import mpma_pkg::*;

	state_t state_q, state_d;
	field_t op_q, op_d;
	field_t ii_q, ii_d;
	field_t oi_q, oi_d;
	addr_t  scan_q, scan_d;
	mask_t  free_q, free_d;
	cnt_t   cnt_q, cnt_d;
	logic   res_valid_q, res_valid_d;
	field_t res_idx_q, res_idx_d;
	logic   res_last_q, res_last_d;

	addr_t  low;
	mask_t  low_bit;
	mask_t  rest;
	mask_t  used_bit;
	logic   at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q        <= op_d;
		ii_q        <= ii_d;
		oi_q        <= oi_d;
		scan_q      <= scan_d;
		free_q      <= free_d;
		cnt_q       <= cnt_d;
		res_valid_q <= res_valid_d;
		res_idx_q   <= res_idx_d;
		res_last_q  <= res_last_d;
	end

	always_comb begin
		low      = lowest(free_q);
		low_bit  = mask_t'(1) << low;
		rest     = free_q & ~low_bit;
		used_bit = mask_t'(1) << to_addr(rd_data.target);
		at_end   = (scan_q == LAST_ADDR);

		state_d     = state_q;
		op_d        = op_q;
		ii_d        = ii_q;
		oi_d        = oi_q;
		scan_d      = scan_q;
		free_d      = free_q;
		cnt_d       = cnt_q;
		res_valid_d = res_valid_q;
		res_idx_d   = res_idx_q;
		res_last_d  = res_last_q;
		wr          = '0;
		rd_addr     = (state_q == ST_EXEC) ? to_addr(ii_q) : scan_q;

		in_ch.ready = (state_q == ST_IDLE);
		out_ch.valid       = (state_q == ST_WAIT);
		out_ch.index_valid = res_valid_q;
		out_ch.out_index   = res_idx_q;
		out_ch.last        = res_last_q;

		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					op_d    = in_ch.op;
					ii_d    = in_ch.in_sel;
					oi_d    = in_ch.out_sel;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				scan_d = '0;
				free_d = '1;
				cnt_d  = '0;
				unique case (op_q)
					OP_CONNECT: begin
						wr.en          = in_range(ii_q) && in_range(oi_q);
						wr.addr        = to_addr(ii_q);
						wr.data.valid  = 1'b1;
						wr.data.target = oi_q;
						state_d        = ST_IDLE;
					end
					OP_DISCONNECT: begin
						wr.en   = in_range(ii_q);
						wr.addr = to_addr(ii_q);
						state_d = ST_IDLE;
					end
					OP_LOOKUP: begin
						res_valid_d = in_range(ii_q) && rd_data.valid;
						res_idx_d   = res_valid_d ? rd_data.target : '0;
						res_last_d  = 1'b1;
						state_d     = ST_WAIT;
					end
					OP_LIST_FREE: begin
						if (!in_range(ii_q) || rd_data.valid) begin
							res_valid_d = 1'b0;
							res_idx_d   = '0;
							res_last_d  = 1'b1;
							state_d     = ST_WAIT;
						end else begin
							state_d = ST_SCAN;
						end
					end
					OP_FILL: begin
						state_d = ST_SCAN;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_SCAN: begin
				// a mapped entry takes its output out of the free mask
				if (rd_data.valid && in_range(rd_data.target)) begin
					free_d = free_q & ~used_bit;
				end
				scan_d = scan_q + addr_t'(1);
				if (at_end) begin
					scan_d  = '0;
					state_d = (op_q == OP_FILL) ? ST_FILL : ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (free_q == '0) begin
					res_valid_d = 1'b0;
					res_idx_d   = '0;
					res_last_d  = 1'b1;
				end else begin
					res_valid_d = 1'b1;
					res_idx_d   = to_field(low);
					res_last_d  = (rest == '0) || (cnt_q == LAST_CNT);
					free_d      = rest;
					cnt_d       = cnt_q + cnt_t'(1);
				end
				state_d = ST_WAIT;
			end
			ST_FILL: begin
				if (!rd_data.valid && free_q != '0) begin
					wr.en          = 1'b1;
					wr.addr        = scan_q;
					wr.data.valid  = 1'b1;
					wr.data.target = to_field(low);
					free_d         = rest;
				end
				scan_d = scan_q + addr_t'(1);
				if (at_end) begin
					scan_d  = '0;
					state_d = ST_IDLE;
				end
			end
			ST_WAIT: begin
				if (out_ch.ready) begin
					state_d = res_last_q ? ST_IDLE : ST_EMIT;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

[src/mux_port_mapping_allocator_core.sv]
// Mux port mapping allocator: keeps one mapping entry per mux input (8 inputs, 8 outputs)
// and serves connect, disconnect, lookup, list_free and fill_remaining requests one at a
// time. Every entry is read through a single table read port, addressed by the input
// select or stepped by a scan counter: connect, disconnect and unknown codes are taken,
// then executed; lookup reads its entry, then offers the result beat; list_free scans
// every entry to build the free mask, then forms each result beat and holds it until it
// is handed over; fill_remaining scans every entry, then fills unmapped entries in a
// second walk and gives no result. The request channel is not ready while a request is
// being served or a result waits. After reset all inputs are unmapped and it is ready.
`default_nettype none

module mux_port_mapping_allocator_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mpma_in_if.sink    in_ch,
	mpma_out_if.source out_ch
);
	import mpma_pkg::*;

	tbl_wr_t wr;
	addr_t   rd_addr;
	entry_t  rd_data;

	mpma_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mpma_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// the table is never written while a new request can be taken
	a_no_write_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !in_ch.ready)
		else $error("table written while request channel ready");

	// a pending result beat and an open request channel exclude each other
	a_out_excl_in: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_ch.valid && in_ch.ready))
		else $error("result pending while request channel ready");

	// an accepted request closes the channel on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("request channel still ready after accept");

	// an empty result is always the final beat with a zero index
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.index_valid) |-> (out_ch.last && out_ch.out_index == '0))
		else $error("empty result beat not final or index not zero");

endmodule

`default_nettype wire

[tb/mapping_result_checker.sv]
// checker that mirrors the mapping table and compares every result beat
`default_nettype none

module mapping_result_checker
	import mpma_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	mpma_in_if        req_mon,
	mpma_out_if       res_mon,
	output int        fail_count,
	output int        pending,
	output int        beats_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic   index_valid;
		field_t out_index;
		logic   last;
	} result_t;

	field_t  map_tgt [NUM_PORTS];
	logic    map_vld [NUM_PORTS];
	result_t expected_results [$];
	result_t head;
	int      errors;
	int      beats;

	function automatic void push_result(logic v, field_t idx, logic lst);
		result_t r;
		r.index_valid = v;
		r.out_index   = v ? idx : '0;
		r.last        = lst;
		expected_results.push_back(r);
	endfunction

	// applies one request to the mirrored table and queues the beats it causes
	function automatic void predict_request(field_t op, field_t ii, field_t oi);
		logic is_free [NUM_PORTS];
		logic in_ok;
		int   next_out;
		int   n_free;
		int   n_emit;
		int   k;
		in_ok = int'(ii) < NUM_PORTS;
		for (int i = 0; i < NUM_PORTS; i++) begin
			is_free[i] = 1'b1;
		end
		for (int i = 0; i < NUM_PORTS; i++) begin
			if (map_vld[i] && int'(map_tgt[i]) < NUM_PORTS) begin
				is_free[int'(map_tgt[i])] = 1'b0;
			end
		end
		case (op)
			OP_CONNECT: begin
				if (in_ok && int'(oi) < NUM_PORTS) begin
					map_tgt[ii] = oi;
					map_vld[ii] = 1'b1;
				end
			end
			OP_DISCONNECT: begin
				if (in_ok) begin
					map_vld[ii] = 1'b0;
					map_tgt[ii] = '0;
				end
			end
			OP_LOOKUP: begin
				if (in_ok && map_vld[ii]) begin
					push_result(1'b1, map_tgt[ii], 1'b1);
				end else begin
					push_result(1'b0, '0, 1'b1);
				end
			end
			OP_LIST_FREE: begin
				n_free = 0;
				if (in_ok && !map_vld[ii]) begin
					for (int i = 0; i < NUM_PORTS; i++) begin
						if (is_free[i]) begin
							n_free++;
						end
					end
				end
				n_emit = (n_free > MAX_RESULTS) ? MAX_RESULTS : n_free;
				if (n_emit == 0) begin
					push_result(1'b0, '0, 1'b1);
				end else begin
					k = 0;
					for (int i = 0; i < NUM_PORTS && k < n_emit; i++) begin
						if (is_free[i]) begin
							push_result(1'b1, field_t'(i), k == n_emit - 1);
							k++;
						end
					end
				end
			end
			OP_FILL: begin
				next_out = 0;
				for (int i = 0; i < NUM_PORTS; i++) begin
					if (!map_vld[i]) begin
						while (next_out < NUM_PORTS && !is_free[next_out]) begin
							next_out++;
						end
						if (next_out >= NUM_PORTS) begin
							break;
						end
						map_tgt[i] = field_t'(next_out);
						map_vld[i] = 1'b1;
						next_out++;
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PORTS; i++) begin
				map_tgt[i] = '0;
				map_vld[i] = 1'b0;
			end
			expected_results.delete();
			errors        = 0;
			beats         = 0;
			fail_count    <= 0;
			pending       <= 0;
			beats_checked <= 0;
		end else begin
			// result beats belong to earlier requests, so they are taken first
			if (res_mon.valid && res_mon.ready) begin
				beats++;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat, expected none, %s %0b index %0d last %0b",
						$time, "actual valid", res_mon.index_valid, res_mon.out_index,
						res_mon.last);
				end else begin
					head = expected_results.pop_front();
					check_field("index_valid", head.index_valid, res_mon.index_valid);
					check_field("out_index", head.out_index, res_mon.out_index);
					check_field("last", head.last, res_mon.last);
				end
			end
			if (req_mon.valid && req_mon.ready) begin
				predict_request(req_mon.op, req_mon.in_sel, req_mon.out_sel);
			end
			fail_count    <= errors;
			pending       <= expected_results.size();
			beats_checked <= beats;
		end
	end

endmodule

`default_nettype wire

[tb/tb.sv]
// top of the allocator testbench: clock, reset, request stimulus, result stalls and verdict
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mpma_pkg::*;

	localparam int     HALF_PERIOD  = 4;
	localparam int     RESET_CYCLES = 12;
	localparam int     TOTAL_ITEMS  = 450;
	localparam int     QUIET_FROM   = 390;
	localparam int     HOLD_AT      = 150;
	localparam int     LONG_HOLD    = 300;
	localparam int     DRAIN_CYCLES = 64;
	localparam int     FIELD_MAX    = (1 << FIELD_W) - 1;
	localparam field_t OP_SPARE_FIRST = 3'd5;
	localparam field_t OP_SPARE_LAST  = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   beats_checked;
	int   items_sent;
	int   spare_count;
	int   op_count [1 << FIELD_W];
	logic quiet_tail;
	logic long_hold_active;
	logic long_hold_done;

	mpma_in_if  req_ch ();
	mpma_out_if res_ch ();

	mux_port_mapping_allocator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_ch),
		.out_ch (res_ch)
	);

	mapping_result_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_mon       (req_ch),
		.res_mon       (res_ch),
		.fail_count    (fail_count),
		.pending       (pending),
		.beats_checked (beats_checked)
	);

	always #(HALF_PERIOD) clk = ~clk;

	initial begin
		#5_000_000;
		$display("tb: timed out with %0d beats still outstanding", pending);
		$display("tb: failure");
		$finish;
	end

	// offers one request and returns once it is taken, at times after a random idle gap
	task automatic send_request(field_t op, field_t ii, field_t oi);
		int gap;
		req_ch.valid   <= 1'b1;
		req_ch.op      <= op;
		req_ch.in_sel  <= ii;
		req_ch.out_sel <= oi;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		items_sent++;
		op_count[op]++;
		if (op >= OP_SPARE_FIRST) begin
			spare_count++;
		end
		if (!quiet_tail && !long_hold_active && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// result side: random stall bursts and one long hold-off
	initial begin
		int stall_left;
		stall_left = 0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
				if (stall_left == 0) begin
					long_hold_active = 1'b0;
				end
			end else if (!long_hold_done && items_sent >= HOLD_AT) begin
				long_hold_done   = 1'b1;
				long_hold_active = 1'b1;
				stall_left       = LONG_HOLD - 1;
				res_ch.ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 15) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int     pick;
		field_t ii;
		field_t oi;
		arst_n <= 1'b0;
		req_ch.valid   <= 1'b0;
		req_ch.op      <= OP_CONNECT;
		req_ch.in_sel  <= '0;
		req_ch.out_sel <= '0;
		quiet_tail       = 1'b0;
		long_hold_active = 1'b0;
		long_hold_done   = 1'b0;
		items_sent       = 0;
		spare_count      = 0;
		foreach (op_count[i]) begin
			op_count[i] = 0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, conflict, mapped list, spare codes, fill
		send_request(OP_LOOKUP, '0, '0);
		send_request(OP_LIST_FREE, '0, '0);
		send_request(OP_CONNECT, '0, field_t'(FIELD_MAX));
		send_request(OP_CONNECT, field_t'(FIELD_MAX), '0);
		send_request(OP_LOOKUP, '0, field_t'(FIELD_MAX));
		send_request(OP_LOOKUP, field_t'(FIELD_MAX), '0);
		send_request(OP_CONNECT, 3'd3, field_t'(FIELD_MAX));
		send_request(OP_LIST_FREE, 3'd1, '0);
		send_request(OP_LIST_FREE, '0, '0);
		send_request(OP_DISCONNECT, 3'd3, field_t'(FIELD_MAX));
		send_request(OP_LOOKUP, 3'd3, '0);
		send_request(OP_SPARE_FIRST, field_t'(FIELD_MAX), field_t'(FIELD_MAX));
		send_request(OP_SPARE_FIRST + 3'd1, 3'd2, 3'd5);
		send_request(OP_SPARE_LAST, '0, '0);
		send_request(OP_LOOKUP, '0, '0);
		send_request(OP_CONNECT, 3'd4, 3'd4);
		send_request(OP_CONNECT, 3'd5, 3'd4);
		send_request(OP_FILL, '0, '0);
		send_request(OP_LIST_FREE, 3'd2, '0);
		send_request(OP_LOOKUP, 3'd6, '0);
		send_request(OP_DISCONNECT, '0, '0);
		send_request(OP_DISCONNECT, field_t'(FIELD_MAX), '0);
		send_request(OP_LIST_FREE, field_t'(FIELD_MAX), field_t'(FIELD_MAX));

		while (items_sent < TOTAL_ITEMS) begin
			quiet_tail = (items_sent >= QUIET_FROM);
			pick = $urandom_range(0, 99);
			ii   = field_t'($urandom_range(0, FIELD_MAX));
			oi   = field_t'($urandom_range(0, FIELD_MAX));
			if (pick < 3) begin
				// sweep the table empty so list_free sees long free lists again
				for (int i = 0; i < NUM_PORTS; i++) begin
					send_request(OP_DISCONNECT, field_t'(i),
						field_t'($urandom_range(0, FIELD_MAX)));
				end
			end else if (pick < 33) begin
				send_request(OP_CONNECT, ii, oi);
			end else if (pick < 50) begin
				send_request(OP_DISCONNECT, ii, oi);
			end else if (pick < 68) begin
				send_request(OP_LOOKUP, ii, oi);
			end else if (pick < 90) begin
				send_request(OP_LIST_FREE, ii, oi);
			end else if (pick < 96) begin
				send_request(OP_FILL, ii, oi);
			end else begin
				send_request(field_t'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), ii, oi);
			end
		end
		req_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d requests: connect %0d, disconnect %0d, lookup %0d,",
			items_sent, op_count[OP_CONNECT], op_count[OP_DISCONNECT], op_count[OP_LOOKUP]);
		$display("tb: list_free %0d, fill %0d, spare %0d; %0d result beats checked",
			op_count[OP_LIST_FREE], op_count[OP_FILL], spare_count, beats_checked);
		$display("tb: one %0d-cycle result hold-off, idle bursts on both sides", LONG_HOLD);
		if (fail_count == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire

[mux_port_mapping_allocator_core.f]
src/mpma_pkg.sv
src/mpma_if.sv
src/mpma_table.sv
src/mpma_ctrl.sv
src/mux_port_mapping_allocator_core.sv
tb/mapping_result_checker.sv
tb/tb.sv
